FILE: rtl/core/pwv_pkg.sv
// pwv_pkg: shared types and constants of the prepared write validator
// holds status codes, request and result beats, slot lookup and slot update structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pwv_pkg;

    // field widths
    localparam int LINK_W     = 4;
    localparam int ATTR_W     = 8;
    localparam int VLEN_W     = 10;
    localparam int OFS_W      = 16;
    localparam int LEN_W      = 16;
    localparam int FLAGS_W    = 3;
    localparam int GEN_W      = 32;
    localparam int STATUS_W   = 3;
    // slot index wide enough for the largest slot count
    localparam int SLOT_IDX_W = 4;
    // number of attribute codes the attr_id field can carry
    localparam int ATTR_CODES = 1 << ATTR_W;

    // write flag bit positions
    localparam int F_PREP_BIT = 0;
    localparam int F_EXEC_BIT = 1;
    localparam int F_CMD_BIT  = 2;

    // reset value of the payload limit
    localparam logic [VLEN_W-1:0] MAX_PAYLOAD_RST = VLEN_W'(512);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_UNLIKELY = 3'd1,
        ST_BAD_LEN  = 3'd2,
        ST_BAD_OFS  = 3'd3,
        ST_UNAUTH   = 3'd4,
        ST_UNSUP    = 3'd5,
        ST_FULL     = 3'd6
    } t_status;

    // one request beat, held while the item is worked on
    typedef struct packed {
        logic [LINK_W-1:0]  link;
        logic               attr_valid;
        logic [ATTR_W-1:0]  attr;
        logic [VLEN_W-1:0]  cap;
        logic               link_active;
        logic               buffer_present;
        logic [OFS_W-1:0]   offset;
        logic [LEN_W-1:0]   length;
        logic [FLAGS_W-1:0] flags;
        logic               authorized;
        logic [GEN_W-1:0]   gen;
    } t_req;

    // one result beat
    typedef struct packed {
        t_status            status;
        logic [VLEN_W-1:0]  accepted_bytes;
        logic               commit;
        logic [VLEN_W-1:0]  commit_offset;
        logic [VLEN_W-1:0]  value_length_after;
        logic               no_response;
    } t_result;

    // slot lookup by link, plus first free slot if the hit slot were vacated
    typedef struct packed {
        logic                  hit;
        logic [SLOT_IDX_W-1:0] idx;
        logic [ATTR_W-1:0]     attr;
        logic [GEN_W-1:0]      gen;
        logic [VLEN_W-1:0]     length;
        logic                  free_any;
        logic [SLOT_IDX_W-1:0] free_idx;
    } t_slot_look;

    // slot update: drop one slot, then write one slot (write wins on same index)
    typedef struct packed {
        logic                  drop_en;
        logic [SLOT_IDX_W-1:0] drop_idx;
        logic                  wr_en;
        logic [SLOT_IDX_W-1:0] wr_idx;
        logic [LINK_W-1:0]     link;
        logic [ATTR_W-1:0]     attr;
        logic [GEN_W-1:0]      gen;
        logic [VLEN_W-1:0]     length;
    } t_slot_cmd;

endpackage

`default_nettype wire

FILE: rtl/core/prepared_write_validator.sv
// prepared_write_validator: attribute write checker with per-link prepared write queue
// the request beat is held in a register; the result is registered once the output register is free
// a new request is taken only after the held one has finished, set by the read-modify-write of the length memory
// a finished result waits in the output register while the next request is taken
// reset: synchronous, active low; the length memory is cleared in a clearing pass after reset,
// during which no request is taken (configuration writes are taken at all times)
`timescale 1ns / 1ps
`default_nettype none

module prepared_write_validator
    import pwv_pkg::*;
#(
    parameter int SLOTS     = 4,
    parameter int ATTRS     = 256,
    parameter int VALUE_MAX = 512
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [VLEN_W-1:0]  i_cfg_max_payload,
    // request channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [LINK_W-1:0]  i_link_id,
    input  wire logic               i_attr_valid,
    input  wire logic [ATTR_W-1:0]  i_attr_id,
    input  wire logic [VLEN_W-1:0]  i_attr_capacity,
    input  wire logic               i_link_active,
    input  wire logic               i_buffer_present,
    input  wire logic [OFS_W-1:0]   i_offset,
    input  wire logic [LEN_W-1:0]   i_length,
    input  wire logic [FLAGS_W-1:0] i_write_flags,
    input  wire logic               i_authorized,
    input  wire logic [GEN_W-1:0]   i_session_gen,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [STATUS_W-1:0]     o_status,
    output logic [VLEN_W-1:0]       o_accepted_bytes,
    output logic                    o_commit,
    output logic [VLEN_W-1:0]       o_commit_offset,
    output logic [VLEN_W-1:0]       o_value_length_after,
    output logic                    o_no_response
);

    localparam int AW = (ATTRS > 1) ? $clog2(ATTRS) : 1;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [VLEN_W-1:0] r_max_payload;
    logic              r_busy;
    t_req              r_req;
    logic [AW-1:0]     r_ai;
    logic              r_out_valid;
    t_result           r_out;

    logic [AW-1:0]     w_ai_tab [ATTR_CODES];
    logic              w_mem_ready;
    logic [VLEN_W-1:0] w_old_len;
    logic              w_in_beat;
    logic              w_done;
    t_slot_look        w_look;
    t_result           w_res;
    logic              w_len_wr;
    logic [VLEN_W-1:0] w_len_data;
    t_slot_cmd         w_cmd;

    // attribute code to length table index, wrapping at ATTRS
    for (genvar g = 0; g < ATTR_CODES; g++) begin : g_ai_tab
        assign w_ai_tab[g] = AW'(g % ATTRS);
    end

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_busy && w_mem_ready;
    assign w_in_beat   = i_in_valid && o_in_ready;
    assign w_done      = r_busy && (!r_out_valid || i_out_ready);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (i_cfg_valid) begin
            r_max_payload <= i_cfg_max_payload;
        end
    end

    // control: request held, result waiting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_beat) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_req.link           <= i_link_id;
            r_req.attr_valid     <= i_attr_valid;
            r_req.attr           <= i_attr_id;
            r_req.cap            <= i_attr_capacity;
            r_req.link_active    <= i_link_active;
            r_req.buffer_present <= i_buffer_present;
            r_req.offset         <= i_offset;
            r_req.length         <= i_length;
            r_req.flags          <= i_write_flags;
            r_req.authorized     <= i_authorized;
            r_req.gen            <= i_session_gen;
            r_ai                 <= w_ai_tab[i_attr_id];
        end
        if (w_done) begin
            r_out <= w_res;
        end
    end

    // stored value lengths
    pwv_len_mem #(
        .ATTRS (ATTRS),
        .AW    (AW)
    ) u_len_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_in_beat),
        .i_rd_addr (w_ai_tab[i_attr_id]),
        .o_rd_data (w_old_len),
        .i_wr_en   (w_done && w_len_wr),
        .i_wr_addr (r_ai),
        .i_wr_data (w_len_data),
        .o_ready   (w_mem_ready)
    );

    // prepared write slots
    pwv_slot_table #(
        .SLOTS (SLOTS),
        .SW    (SW)
    ) u_slot_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_link  (r_req.link),
        .o_look  (w_look),
        .i_apply (w_done),
        .i_cmd   (w_cmd)
    );

    // request checks and write handling
    pwv_decide #(
        .VALUE_MAX (VALUE_MAX)
    ) u_decide (
        .i_req         (r_req),
        .i_old_len     (w_old_len),
        .i_max_payload (r_max_payload),
        .i_look        (w_look),
        .o_res         (w_res),
        .o_len_wr      (w_len_wr),
        .o_len_data    (w_len_data),
        .o_cmd         (w_cmd)
    );

    // result ports
    assign o_out_valid          = r_out_valid;
    assign o_status             = r_out.status;
    assign o_accepted_bytes     = r_out.accepted_bytes;
    assign o_commit             = r_out.commit;
    assign o_commit_offset      = r_out.commit_offset;
    assign o_value_length_after = r_out.value_length_after;
    assign o_no_response        = r_out.no_response;

endmodule

`default_nettype wire

FILE: rtl/core/pwv_len_mem.sv
// pwv_len_mem: per-attribute stored value length memory
// one write port, one registered read port, clearing pass after reset
// depends on pwv_pkg
`timescale 1ns / 1ps
`default_nettype none

module pwv_len_mem
    import pwv_pkg::*;
#(
    parameter int ATTRS = 256,
    parameter int AW    = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire logic [AW-1:0]     i_rd_addr,
    output logic      [VLEN_W-1:0] o_rd_data,
    input  wire logic              i_wr_en,
    input  wire logic [AW-1:0]     i_wr_addr,
    input  wire logic [VLEN_W-1:0] i_wr_data,
    output logic                   o_ready
);

    logic [VLEN_W-1:0] r_mem [ATTRS];
    logic [VLEN_W-1:0] r_rd_data;
    logic              r_clr_busy;
    logic [AW-1:0]     r_clr_addr;

    // clearing pass, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(ATTRS - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // write port, clearing pass has priority
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = !r_clr_busy;

endmodule

`default_nettype wire

FILE: rtl/core/pwv_slot_table.sv
// pwv_slot_table: per-link prepared write slots in registers
// lookup by link, first free slot search, drop and write updates
// depends on pwv_pkg
`timescale 1ns / 1ps
`default_nettype none

module pwv_slot_table
    import pwv_pkg::*;
#(
    parameter int SLOTS = 4,
    parameter int SW    = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [LINK_W-1:0] i_link,
    output t_slot_look             o_look,
    input  wire logic              i_apply,
    input  wire t_slot_cmd         i_cmd
);

    logic              r_used [SLOTS];
    logic [LINK_W-1:0] r_link [SLOTS];
    logic [ATTR_W-1:0] r_attr [SLOTS];
    logic [GEN_W-1:0]  r_gen  [SLOTS];
    logic [VLEN_W-1:0] r_len  [SLOTS];

    // lowest used slot holding this link, then lowest slot free once it is vacated
    always_comb begin
        o_look = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_used[i] && r_link[i] == i_link) begin
                o_look.hit    = 1'b1;
                o_look.idx    = SLOT_IDX_W'(i);
                o_look.attr   = r_attr[i];
                o_look.gen    = r_gen[i];
                o_look.length = r_len[i];
            end
        end
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i] || (o_look.hit && o_look.idx == SLOT_IDX_W'(i))) begin
                o_look.free_any = 1'b1;
                o_look.free_idx = SLOT_IDX_W'(i);
            end
        end
    end

    // used bits, write wins over drop on the same slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_used[i] <= 1'b0;
            end
        end else if (i_apply) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (i_cmd.wr_en && i_cmd.wr_idx[SW-1:0] == SW'(i)) begin
                    r_used[i] <= 1'b1;
                end else if (i_cmd.drop_en && i_cmd.drop_idx[SW-1:0] == SW'(i)) begin
                    r_used[i] <= 1'b0;
                end
            end
        end
    end

    // slot contents, read only while used
    always_ff @(posedge i_clk) begin
        if (i_apply && i_cmd.wr_en) begin
            r_link[i_cmd.wr_idx[SW-1:0]] <= i_cmd.link;
            r_attr[i_cmd.wr_idx[SW-1:0]] <= i_cmd.attr;
            r_gen[i_cmd.wr_idx[SW-1:0]]  <= i_cmd.gen;
            r_len[i_cmd.wr_idx[SW-1:0]]  <= i_cmd.length;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/pwv_decide.sv
// pwv_decide: request checks and prepare/execute/plain write handling
// combinational; turns a request, slot lookup and stored length into a result
// depends on pwv_pkg
`timescale 1ns / 1ps
`default_nettype none

module pwv_decide
    import pwv_pkg::*;
#(
    parameter int VALUE_MAX = 512
) (
    input  wire t_req              i_req,
    input  wire logic [VLEN_W-1:0] i_old_len,
    input  wire logic [VLEN_W-1:0] i_max_payload,
    input  wire t_slot_look        i_look,
    output t_result                o_res,
    output logic                   o_len_wr,
    output logic      [VLEN_W-1:0] o_len_data,
    output t_slot_cmd              o_cmd
);

    logic [VLEN_W-1:0] w_cap;
    logic [LEN_W:0]    w_end;
    logic [LEN_W:0]    w_plain_len;
    logic              w_prep;
    logic              w_exec;
    logic              w_cmd;
    logic              w_gen_eq;
    logic              w_attr_eq;

    // capacity clamp and end of the write window
    assign w_cap       = (i_req.cap > VLEN_W'(VALUE_MAX)) ? VLEN_W'(VALUE_MAX) : i_req.cap;
    assign w_end       = {1'b0, i_req.offset} + {1'b0, i_req.length};
    assign w_prep      = i_req.flags[F_PREP_BIT];
    assign w_exec      = i_req.flags[F_EXEC_BIT];
    assign w_cmd       = i_req.flags[F_CMD_BIT];
    assign w_gen_eq    = i_look.gen == i_req.gen;
    assign w_attr_eq   = i_look.attr == i_req.attr;

    // new stored length of a plain write
    assign w_plain_len = (i_req.offset == '0) ? {1'b0, i_req.length} :
                         (w_end > (LEN_W+1)'(i_old_len)) ? w_end : (LEN_W+1)'(i_old_len);

    always_comb begin
        o_res          = '0;
        o_res.status   = ST_OK;
        o_len_wr       = 1'b0;
        o_len_data     = '0;
        o_cmd          = '0;
        o_cmd.drop_idx = i_look.idx;
        o_cmd.link     = i_req.link;
        o_cmd.attr     = i_req.attr;
        o_cmd.gen      = i_req.gen;

        // generic checks in order
        if (!i_req.attr_valid || (!i_req.buffer_present && i_req.length != '0)) begin
            o_res.status = ST_UNLIKELY;
        end else if (i_req.length > LEN_W'(i_max_payload)) begin
            o_cmd.drop_en = i_look.hit;
            o_res.status  = ST_BAD_LEN;
        end else if (!i_req.link_active) begin
            o_res.status = ST_UNLIKELY;
        end else if (i_req.length == '0 && (w_prep || w_exec)) begin
            o_cmd.drop_en = i_look.hit;
            o_res.status  = ST_BAD_LEN;
        end else if (i_req.offset > OFS_W'(w_cap)) begin
            o_cmd.drop_en = i_look.hit;
            o_res.status  = ST_BAD_OFS;
        end else if (w_end > (LEN_W+1)'(w_cap)) begin
            o_cmd.drop_en = i_look.hit;
            o_res.status  = ST_BAD_LEN;
        end else if (!i_req.authorized) begin
            o_cmd.drop_en = i_look.hit;
            o_res.status  = ST_UNAUTH;
        end else if (w_prep) begin
            // prepare write
            if (w_cmd || w_exec) begin
                o_cmd.drop_en = i_look.hit;
                o_res.status  = ST_UNSUP;
            end else if (i_look.hit && w_gen_eq && !w_attr_eq) begin
                o_cmd.drop_en = 1'b1;
                o_res.status  = ST_FULL;
            end else if (i_look.hit && w_gen_eq && i_req.offset != '0) begin
                // continue the collected run
                if (i_req.offset != OFS_W'(i_look.length)) begin
                    o_cmd.drop_en = 1'b1;
                    o_res.status  = ST_BAD_OFS;
                end else begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_idx = i_look.idx;
                    o_cmd.length = w_end[VLEN_W-1:0];
                end
            end else begin
                // stale, restarted or absent slot: start over from offset zero
                o_cmd.drop_en = i_look.hit;
                if (i_req.offset != '0) begin
                    o_res.status = ST_BAD_OFS;
                end else if (!i_look.free_any) begin
                    o_res.status = ST_FULL;
                end else begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_idx = i_look.free_idx;
                    o_cmd.length = i_req.length[VLEN_W-1:0];
                end
            end
        end else if (w_exec) begin
            // execute write
            o_cmd.drop_en = i_look.hit;
            if (w_cmd) begin
                o_res.status = ST_UNSUP;
            end else if (!i_look.hit || !w_attr_eq || !w_gen_eq || i_req.offset != '0) begin
                o_res.status = ST_BAD_OFS;
            end else if (LEN_W'(i_look.length) != i_req.length) begin
                o_res.status = ST_BAD_LEN;
            end else begin
                o_len_wr                 = 1'b1;
                o_len_data               = i_req.length[VLEN_W-1:0];
                o_res.accepted_bytes     = i_req.length[VLEN_W-1:0];
                o_res.commit             = 1'b1;
                o_res.value_length_after = i_req.length[VLEN_W-1:0];
            end
        end else if (i_look.hit) begin
            // plain write blocked by a pending prepared run
            o_res.status = ST_FULL;
        end else begin
            // plain write or command
            o_len_wr                 = 1'b1;
            o_len_data               = w_plain_len[VLEN_W-1:0];
            o_res.accepted_bytes     = i_req.length[VLEN_W-1:0];
            o_res.commit             = 1'b1;
            o_res.commit_offset      = i_req.offset[VLEN_W-1:0];
            o_res.value_length_after = w_plain_len[VLEN_W-1:0];
            o_res.no_response        = w_cmd;
        end
    end

endmodule

`default_nettype wire
